// ===== src/bwc_pkg.sv =====
// ----------------------------------------------------------------------------
// bwc_pkg: shared types and constants for the BMP window crop
// Register indexes, dimension limits and the request record that travels
// from the classifier to the output sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bwc_pkg;

  localparam int unsigned MAX_DIM         = 4096;
  localparam int unsigned BYTES_PER_PIXEL = 3;
  localparam int unsigned DIM_W           = 13;
  localparam int unsigned COL_W           = 15;
  localparam int unsigned PAD_W           = 2;
  localparam int unsigned QUEUE_DEPTH     = 4;
  localparam int unsigned QPTR_W          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W          = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned CFG_IDX_W       = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 3'd0,
    REG_SOURCE_HEIGHT = 3'd1,
    REG_WINDOW_LEFT   = 3'd2,
    REG_WINDOW_TOP    = 3'd3,
    REG_WINDOW_WIDTH  = 3'd4,
    REG_WINDOW_HEIGHT = 3'd5
  } bwc_reg_t;

  // One classified request: a window byte or a rejection, plus trailing pad
  typedef struct packed {
    logic [7:0]       data;
    logic             rejected;
    logic [PAD_W-1:0] pad;
    logic             last;
  } bwc_job_t;

  // Saturate a register value at the largest supported dimension
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    return (v > lim) ? lim : v;
  endfunction

  // Zero bytes that round a row of the given pixel count up to a multiple of 4 bytes
  function automatic logic [PAD_W-1:0] row_pad(input logic [DIM_W-1:0] pixels);
    logic [COL_W-1:0] bytes;
    bytes = COL_W'(pixels) * COL_W'(BYTES_PER_PIXEL);
    return PAD_W'(2'd0 - bytes[PAD_W-1:0]);
  endfunction

endpackage

`default_nettype wire

// ===== src/bwc_if.sv =====
// ----------------------------------------------------------------------------
// bwc_if: stream channels of the BMP window crop
// Input channel carries source bytes, output channel carries cropped bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bwc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] source_byte;

  modport source (output valid, output source_byte, input ready);
  modport sink (input valid, input source_byte, output ready);
endinterface

interface bwc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       image_end;
  logic       rejected;

  modport source (output valid, output out_byte, output image_end, output rejected,
                  input ready);
  modport sink (input valid, input out_byte, input image_end, input rejected,
                output ready);
endinterface

`default_nettype wire

// ===== src/bmp_rgb24_window_crop_top.sv =====
// A window byte is written into the request queue and then loaded into the output register.
// Throughput: one source byte per cycle while the request queue is not full;
// each window row end adds 0 to 3 zero padding bytes on the output, absorbed by
// a 4-entry request queue. Bytes outside the window are consumed with no result.
// Reset (rst_n low, synchronous) clears counters, queue and output valid, and
// loads source size 1x1 and an empty window at origin.
// ----------------------------------------------------------------------------
// bmp_rgb24_window_crop_top: crop a window out of 24-bit BMP pixel data
// Classifier front end, request queue and output sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmp_rgb24_window_crop_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bwc_pkg::DIM_W-1:0]      cfg_data,
  bwc_in_if.sink                              in_chan,
  bwc_out_if.source                           out_chan
);
  import bwc_pkg::*;

  bwc_job_t push_job, head_job;
  logic     push, pop, full, empty;

  // Classify incoming bytes
  bwc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_chan.valid),
    .in_byte   (in_chan.source_byte),
    .in_ready  (in_chan.ready),
    .q_full    (full),
    .q_push    (push),
    .q_job     (push_job)
  );

  // Buffer requests
  bwc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head_job (head_job),
    .empty    (empty)
  );

  // Emit results
  bwc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (empty),
    .q_head        (head_job),
    .q_pop         (pop),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .out_byte      (out_chan.out_byte),
    .out_image_end (out_chan.image_end),
    .out_rejected  (out_chan.rejected)
  );

endmodule

`default_nettype wire

// ===== src/bwc_front.sv =====
// ----------------------------------------------------------------------------
// bwc_front: configuration registers, position counters and classifier
// Tracks row and byte position of each source byte and turns the bytes that
// produce output into requests for the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwc_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [bwc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bwc_pkg::DIM_W-1:0]      cfg_data,
  input  wire logic                           in_valid,
  input  wire logic [7:0]                     in_byte,
  output logic                                in_ready,
  input  wire logic                           q_full,
  output logic                                q_push,
  output bwc_pkg::bwc_job_t                   q_job
);
  import bwc_pkg::*;

  logic [DIM_W-1:0] src_w_r, src_h_r, win_x_r, win_y_r, win_w_r, win_h_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;

  logic [DIM_W-1:0] W, H, x, y, w, h;
  logic [COL_W-1:0] row_len, lo, hi;
  logic [15:0]      col_inc, hi16, ry, ryh;
  logic [DIM_W:0]   row_inc;
  logic             win_ok, first, in_rows, in_cols, col_last, accept;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= DIM_W'(1);
      src_h_r <= DIM_W'(1);
      win_x_r <= '0;
      win_y_r <= '0;
      win_w_r <= '0;
      win_h_r <= '0;
    end else if (cfg_we) begin
      case (bwc_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  src_w_r <= cfg_data;
        REG_SOURCE_HEIGHT: src_h_r <= cfg_data;
        REG_WINDOW_LEFT:   win_x_r <= cfg_data;
        REG_WINDOW_TOP:    win_y_r <= cfg_data;
        REG_WINDOW_WIDTH:  win_w_r <= cfg_data;
        REG_WINDOW_HEIGHT: win_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Derive window bounds and validity
  always_comb begin
    W       = clamp_dim(src_w_r);
    H       = clamp_dim(src_h_r);
    x       = clamp_dim(win_x_r);
    y       = clamp_dim(win_y_r);
    w       = clamp_dim(win_w_r);
    h       = clamp_dim(win_h_r);
    row_len = COL_W'(W) * COL_W'(BYTES_PER_PIXEL) + COL_W'(row_pad(W));
    lo      = COL_W'(x) * COL_W'(BYTES_PER_PIXEL);
    hi      = (COL_W'(x) + COL_W'(w)) * COL_W'(BYTES_PER_PIXEL);
    win_ok  = !(((DIM_W+1)'(x) + (DIM_W+1)'(w)) > (DIM_W+1)'(W)) &&
              !(((DIM_W+1)'(y) + (DIM_W+1)'(h)) > (DIM_W+1)'(H)) &&
              !((x >= W) && (y >= H)) &&
              !((w == x) && (y == h));
  end

  // Classify the current byte
  always_comb begin
    col_inc  = 16'(col_r) + 16'd1;
    row_inc  = (DIM_W+1)'(row_r) + (DIM_W+1)'(1);
    hi16     = 16'(hi);
    ry       = 16'(row_r) + 16'(y);
    ryh      = ry + 16'(h);
    first    = (col_r == '0) && (row_r == '0);
    in_rows  = (h != '0) && (ryh >= 16'(H)) && (ry < 16'(H));
    in_cols  = (col_r >= lo) && (col_r < hi);
    col_last = (col_inc == hi16);
    accept   = in_valid && in_ready;

    q_job.data     = win_ok ? in_byte : 8'h00;
    q_job.rejected = !win_ok;
    q_job.pad      = (win_ok && col_last) ? row_pad(w) : '0;
    q_job.last     = win_ok && col_last && ((ry + 16'd1) == 16'(H));
    q_push         = accept && (win_ok ? (in_rows && in_cols) : first);
    in_ready       = !q_full;
  end

  // Advance byte and row counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept) begin
      if (col_inc >= 16'(row_len)) begin
        col_nxt = '0;
        row_nxt = (row_inc >= (DIM_W+1)'(H)) ? '0 : row_inc[DIM_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/bwc_queue.sv =====
// ----------------------------------------------------------------------------
// bwc_queue: request queue between classifier and sequencer
// Small show-ahead FIFO that lets each side stall on its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwc_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire bwc_pkg::bwc_job_t  push_job,
  output logic                    full,
  input  wire logic               pop,
  output bwc_pkg::bwc_job_t       head_job,
  output logic                    empty
);
  import bwc_pkg::*;

  bwc_job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]     count_r, count_nxt;

  // Store pushed requests
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign full     = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);
  assign head_job = mem[rd_ptr_r];

endmodule

`default_nettype wire

// ===== src/bwc_back.sv =====
// ----------------------------------------------------------------------------
// bwc_back: output sequencer
// Pops requests, emits the byte and then its row padding into the output
// register, one result per cycle while the output is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bwc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               q_empty,
  input  wire bwc_pkg::bwc_job_t  q_head,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_byte,
  output logic                    out_image_end,
  output logic                    out_rejected
);
  import bwc_pkg::*;

  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_end_r, out_end_nxt;
  logic             out_rej_r, out_rej_nxt;
  logic [PAD_W-1:0] pad_left_r, pad_left_nxt;
  logic             last_r, last_nxt;
  logic             can_load;

  // Load the output register from padding or from the queue head
  always_comb begin
    can_load      = !out_valid_r || out_ready;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    out_rej_nxt   = out_rej_r;
    pad_left_nxt  = pad_left_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    if (can_load) begin
      if (pad_left_r != '0) begin
        out_valid_nxt = 1'b1;
        out_byte_nxt  = 8'h00;
        out_rej_nxt   = 1'b0;
        out_end_nxt   = last_r && (pad_left_r == PAD_W'(1));
        pad_left_nxt  = pad_left_r - PAD_W'(1);
      end else if (!q_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        out_byte_nxt  = q_head.data;
        out_rej_nxt   = q_head.rejected;
        out_end_nxt   = q_head.last && (q_head.pad == '0);
        pad_left_nxt  = q_head.pad;
        last_nxt      = q_head.last;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pad_left_r  <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pad_left_r  <= pad_left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_end_r  <= out_end_nxt;
    out_rej_r  <= out_rej_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_image_end = out_end_r;
  assign out_rejected  = out_rej_r;

`ifndef ASSERT_OFF
  // Padding only follows a byte that is still held in the output register
  a_pad_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    (pad_left_r != '0) |-> out_valid_r)
    else $error("padding pending without a valid output");

  // A rejection carries a zero byte and never ends an image
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_rej_r) |-> ((out_byte_r == 8'h00) && !out_end_r && (pad_left_r == '0)))
    else $error("rejection result with data, end flag or padding");

  // A stalled output holds the remaining padding count
  a_pad_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> $stable(pad_left_r))
    else $error("padding count moved during a stall");
`endif

endmodule

`default_nettype wire
